/* rtl/dpd_pkg.sv */
package dpd_pkg;

   // Field widths of the request and response ports
   localparam int COORD_FIELD_BITS = 32;
   localparam int OUT_BITS         = 32;

   // Defaults for the top-level parameters
   localparam int COORD_BITS_DEF = 32;
   localparam int INDEX_BITS_DEF = 32;

   // Entries of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Register reset value: test all three projections
   localparam logic MODE_RESET = 1'b1;

   // Saturating vertex count that enables the fan triangle test
   localparam logic [1:0] SEEN_FULL = 2'd2;

   typedef struct packed {
      logic                tri_test;  // a fan triangle exists for this vertex
      logic                three_d;   // projections to test
      logic                last;      // closes the polygon
      logic [OUT_BITS-1:0] index;     // polygon index to report
   } dpd_ctrl_type;

endpackage

/* rtl/dpd_queue.sv */
module dpd_queue
   import dpd_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   assign full      = (count_ff == NW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count lost a write");
`endif

endmodule

/* rtl/dpd_front.sv */
module dpd_front
   import dpd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   localparam int CW = (COORD_BITS < COORD_FIELD_BITS) ? COORD_BITS : COORD_FIELD_BITS,
   localparam int DW = CW + 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [COORD_FIELD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_FIELD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_FIELD_BITS-1:0] req_coord_z,
   input  logic                               req_last_vertex,
   input  logic                               three_d_mode,
   input  logic                               queue_full,
   output logic                               queue_push,
   output dpd_ctrl_type                       entry_ctrl,
   output logic [2:0][DW-1:0]                 entry_d1,
   output logic [2:0][DW-1:0]                 entry_d2
);

   logic [2:0][CW-1:0]    cur;
   logic [2:0][CW-1:0]    anchor_ff, anchor_in;
   logic [2:0][CW-1:0]    prev_ff, prev_in;
   logic [1:0]            seen_ff, seen_in;
   logic [INDEX_BITS-1:0] count_ff, count_in;
   logic                  take;

   assign req_ready  = !queue_full;
   assign take       = req_valid && req_ready;
   assign queue_push = take;

   assign cur[0] = req_coord_x[CW-1:0];
   assign cur[1] = req_coord_y[CW-1:0];
   assign cur[2] = req_coord_z[CW-1:0];

   // Edge vectors from the anchor: previous and current vertex
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         entry_d1[i] = {prev_ff[i][CW-1], prev_ff[i]} - {anchor_ff[i][CW-1], anchor_ff[i]};
         entry_d2[i] = {cur[i][CW-1], cur[i]} - {anchor_ff[i][CW-1], anchor_ff[i]};
      end
      entry_ctrl.tri_test = (seen_ff == SEEN_FULL);
      entry_ctrl.three_d  = three_d_mode;
      entry_ctrl.last     = req_last_vertex;
      entry_ctrl.index    = OUT_BITS'(count_ff);
   end

   always_comb begin
      anchor_in = anchor_ff;
      prev_in   = prev_ff;
      seen_in   = seen_ff;
      count_in  = count_ff;
      if (take) begin
         if (seen_ff == '0) begin
            anchor_in = cur;
         end
         prev_in = cur;
         if (req_last_vertex) begin
            seen_in  = '0;
            count_in = count_ff + 1'b1;
         end else if (seen_ff != SEEN_FULL) begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         count_ff <= '0;
      end else begin
         seen_ff  <= seen_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      anchor_ff <= anchor_in;
      prev_ff   <= prev_in;
   end

endmodule

/* rtl/dpd_back.sv */
module dpd_back
   import dpd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int CW = (COORD_BITS < COORD_FIELD_BITS) ? COORD_BITS : COORD_FIELD_BITS,
   localparam int DW = CW + 1,
   localparam int PW = 2 * DW
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_valid,
   output logic                queue_pop,
   input  dpd_ctrl_type        entry_ctrl,
   input  logic [2:0][DW-1:0]  entry_d1,
   input  logic [2:0][DW-1:0]  entry_d2,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OUT_BITS-1:0] rsp_degenerate_index
);

   logic                       adv;
   logic                       s1_valid_ff, s1_valid_in;
   dpd_ctrl_type               s1_ctrl_ff, s1_ctrl_in;
   logic signed [2:0][PW-1:0]  lhs_ff, lhs_in;
   logic signed [2:0][PW-1:0]  rhs_ff, rhs_in;
   logic                       flat_ff, flat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]        index_ff, index_in;
   logic signed [DW-1:0]       a1 [3];
   logic signed [DW-1:0]       a2 [3];
   logic                       eq_xy, eq_yz, eq_zx, tri_flat, emit;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign queue_pop = adv && queue_valid;

   // Cross products per projection: xy, yz, zx
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a1[i] = $signed(entry_d1[i]);
         a2[i] = $signed(entry_d2[i]);
      end
      lhs_in[0] = PW'(a1[0]) * PW'(a2[1]);
      rhs_in[0] = PW'(a1[1]) * PW'(a2[0]);
      lhs_in[1] = PW'(a1[1]) * PW'(a2[2]);
      rhs_in[1] = PW'(a1[2]) * PW'(a2[1]);
      lhs_in[2] = PW'(a1[2]) * PW'(a2[0]);
      rhs_in[2] = PW'(a1[0]) * PW'(a2[2]);
      s1_ctrl_in  = entry_ctrl;
      s1_valid_in = adv ? queue_valid : s1_valid_ff;
   end

   always_comb begin
      eq_xy    = (lhs_ff[0] == rhs_ff[0]);
      eq_yz    = (lhs_ff[1] == rhs_ff[1]);
      eq_zx    = (lhs_ff[2] == rhs_ff[2]);
      tri_flat = !s1_ctrl_ff.tri_test || (eq_xy && (!s1_ctrl_ff.three_d || (eq_yz && eq_zx)));
      emit     = s1_valid_ff && s1_ctrl_ff.last && flat_ff && tri_flat;

      flat_in      = flat_ff;
      rsp_valid_in = rsp_valid_ff;
      index_in     = index_ff;
      if (adv) begin
         rsp_valid_in = emit;
         if (emit) begin
            index_in = s1_ctrl_ff.index;
         end
         if (s1_valid_ff) begin
            flat_in = s1_ctrl_ff.last ? 1'b1 : (flat_ff && tri_flat);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         flat_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         flat_ff      <= flat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         s1_ctrl_ff <= s1_ctrl_in;
         lhs_ff     <= lhs_in;
         rhs_ff     <= rhs_in;
      end
      index_ff <= index_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_degenerate_index = index_ff;

`ifndef SYNTHESIS
   a_emit_on_last: assert property (@(posedge clock) disable iff (reset)
      adv && !(s1_valid_ff && s1_ctrl_ff.last) |=> !rsp_valid_ff)
      else $error("result raised without a closing vertex");
   a_flat_rearm: assert property (@(posedge clock) disable iff (reset)
      adv && s1_valid_ff && s1_ctrl_ff.last |=> flat_ff)
      else $error("collinear flag not rearmed after polygon end");
   a_flat_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(flat_ff))
      else $error("collinear flag moved while back end stalled");
`endif

endmodule

/* rtl/degenerate_polygon_detector_unit.sv */
// A closing vertex accepted at the request port passes the queue, the s1 registers and the response register.
// Throughput: one vertex request per cycle, bounded only by the response handshake.
// A four-entry queue between front and back absorbs response stalls before req_ready drops.
// Reset (synchronous, active high): empties queue and pipeline, clears vertex count and
// polygon index, sets the collinear flag and selects three-projection mode.
module degenerate_polygon_detector_unit
   import dpd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // vertex requests
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [COORD_FIELD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_FIELD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_FIELD_BITS-1:0] req_coord_z,
   input  logic                               req_last_vertex,
   // degenerate polygon responses
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [OUT_BITS-1:0]                rsp_degenerate_index,
   // mode register
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data
);

   localparam int CW     = (COORD_BITS < COORD_FIELD_BITS) ? COORD_BITS : COORD_FIELD_BITS;
   localparam int DW     = CW + 1;
   localparam int CTRL_W = $bits(dpd_ctrl_type);
   localparam int QW     = CTRL_W + 6 * DW;

   logic               mode_ff, mode_in;
   logic               q_push, q_full, q_pop, q_not_empty;
   dpd_ctrl_type       f_ctrl, b_ctrl;
   logic [2:0][DW-1:0] f_d1, f_d2, b_d1, b_d2;
   logic [QW-1:0]      q_wdata, q_rdata;

   // Mode register: write-only, taken whenever the enable is high
   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Front: hold anchor and previous vertex, form edge vectors, count polygons
   dpd_front #(
      .COORD_BITS (COORD_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_last_vertex (req_last_vertex),
      .three_d_mode    (mode_ff),
      .queue_full      (q_full),
      .queue_push      (q_push),
      .entry_ctrl      (f_ctrl),
      .entry_d1        (f_d1),
      .entry_d2        (f_d2)
   );

   // Pack one request's work into a queue entry and unpack it on the far side
   assign q_wdata = {f_ctrl, f_d1, f_d2};
   assign {b_ctrl, b_d1, b_d2} = q_rdata;

   dpd_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_rdata)
   );

   // Back: multiply, compare, fold the polygon's collinear flag, drive the response
   dpd_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .queue_valid          (q_not_empty),
      .queue_pop            (q_pop),
      .entry_ctrl           (b_ctrl),
      .entry_d1             (b_d1),
      .entry_d2             (b_d2),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_degenerate_index (rsp_degenerate_index)
   );

endmodule
